// ----- rtl/wrs_pkg.sv -----
// shared types and constants for the weighted residual sums block
`default_nettype none
package wrs_pkg;

    // operation codes
    localparam logic [1:0] OP_SINGLE = 2'd0;
    localparam logic [1:0] OP_PAIR   = 2'd1;
    localparam logic [1:0] OP_CHANGE = 2'd2;

    // field widths
    localparam int W_WIDTH   = 33;
    localparam int S2_WIDTH  = 62;
    localparam int RES_WIDTH = 33;
    localparam int ACC_WIDTH = 64;

    // residual limit, 2^32 - 1
    localparam logic signed [63:0] RES_LIMIT = 64'sh0000_0000_FFFF_FFFF;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // one classified request handed from front to back
    typedef struct packed {
        logic signed [W_WIDTH-1:0]   w;
        logic [S2_WIDTH-1:0]         s2;
        logic signed [RES_WIDTH-1:0] res;
        logic                        res_sat;
        logic                        last;
    } wrs_entry_t;

endpackage
`default_nettype wire

// ----- rtl/wrs_front.sv -----
// front end: accepts requests, forms weight, variance and saturated residual
`default_nettype none
module wrs_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          op,
    input  wire logic signed [31:0]  coef_a,
    input  wire logic signed [31:0]  coef_b,
    input  wire logic signed [31:0]  data_value,
    input  wire logic signed [31:0]  approx_value,
    input  wire logic [30:0]         std_dev,
    input  wire logic signed [31:0]  change,
    input  wire logic                last,
    output logic                     q_push,
    output wrs_pkg::wrs_entry_t      q_data,
    input  wire logic                q_full
);
    import wrs_pkg::*;

    // capture stage
    logic              a_valid_reg;
    logic [1:0]        a_op_reg;
    logic signed [31:0] a_a_reg, a_b_reg, a_d_reg, a_ap_reg, a_ch_reg;
    logic [30:0]       a_s_reg;
    logic              a_last_reg;

    // product stage
    logic                        b_valid_reg;
    logic signed [W_WIDTH-1:0]   b_w_reg;
    logic [S2_WIDTH-1:0]         b_s2_reg;
    logic signed [32:0]          b_dap_reg;
    logic signed [63:0]          b_prod_reg;
    logic                        b_last_reg;

    logic advance;
    logic load_a;
    logic signed [63:0] res_wide;
    logic signed [63:0] prod_shift;

    // pipeline moves unless the queue blocks the product stage
    assign advance = !(b_valid_reg && q_full);
    assign load_a  = advance || !a_valid_reg;
    assign full    = !load_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_a)
                a_valid_reg <= push;
            if (advance)
                b_valid_reg <= a_valid_reg;
        end
    end

    // capture payload
    always_ff @(posedge clk)
    begin
        if (load_a && push)
        begin
            a_op_reg   <= op;
            a_a_reg    <= coef_a;
            a_b_reg    <= coef_b;
            a_d_reg    <= data_value;
            a_ap_reg   <= approx_value;
            a_s_reg    <= std_dev;
            a_ch_reg   <= change;
            a_last_reg <= last;
        end
    end

    // weight, variance, change product
    always_ff @(posedge clk)
    begin
        if (advance && a_valid_reg)
        begin
            if (a_op_reg == OP_PAIR)
                b_w_reg <= 33'(a_a_reg) - 33'(a_b_reg);
            else
                b_w_reg <= 33'(a_a_reg);
            b_s2_reg  <= 62'(a_s_reg) * 62'(a_s_reg);
            b_dap_reg <= 33'(a_d_reg) - 33'(a_ap_reg);
            if (a_op_reg == OP_CHANGE)
                b_prod_reg <= 64'(a_ch_reg) * 64'(a_a_reg);
            else
                b_prod_reg <= 64'sd0;
            b_last_reg <= a_last_reg;
        end
    end

    // residual with floor shift and saturation
    assign prod_shift = b_prod_reg >>> FRAC_BITS;
    assign res_wide   = 64'(b_dap_reg) - prod_shift;

    always_comb
    begin
        q_data.w    = b_w_reg;
        q_data.s2   = b_s2_reg;
        q_data.last = b_last_reg;
        if (res_wide > RES_LIMIT)
        begin
            q_data.res     = 33'(RES_LIMIT);
            q_data.res_sat = 1'b1;
        end
        else if (res_wide < -RES_LIMIT)
        begin
            q_data.res     = 33'(-RES_LIMIT);
            q_data.res_sat = 1'b1;
        end
        else
        begin
            q_data.res     = 33'(res_wide);
            q_data.res_sat = 1'b0;
        end
    end

    assign q_push = b_valid_reg && !q_full;

endmodule
`default_nettype wire

// ----- rtl/wrs_fifo.sv -----
// short queue between front and back
`default_nettype none
module wrs_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire wrs_pkg::wrs_entry_t wr_data,
    output logic                     q_full,
    input  wire logic                rd_en,
    output wrs_pkg::wrs_entry_t      rd_data,
    output logic                     q_empty
);
    import wrs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    wrs_entry_t       mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign q_full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/wrs_back.sv -----
// back end: bit-serial ratio divider, products and saturating accumulators
`default_nettype none
module wrs_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wrs_pkg::wrs_entry_t q_data,
    input  wire logic                q_empty,
    output logic                     q_pop,
    output logic                     empty,
    input  wire logic                pop,
    output logic signed [63:0]       sum_s,
    output logic signed [63:0]       sum_s_mu,
    output logic                     saturated
);
    import wrs_pkg::*;

    localparam int NW = W_WIDTH + 2 * FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_FIN, ST_MUL, ST_ACC} state_t;

    state_t                       state_reg;
    logic [CW-1:0]                cnt_reg;
    wrs_entry_t                   ent_reg;
    logic                         neg_reg;
    logic                         zero_reg;
    logic [NW-1:0]                num_reg;
    logic [S2_WIDTH-1:0]          rem_reg;
    logic [32:0]                  quo_reg;
    logic                         ovf_reg;
    logic signed [31:0]           ratio_reg;
    logic                         div_sat_reg;
    logic signed [ACC_WIDTH-1:0]  pw_reg, pr_reg;
    logic signed [ACC_WIDTH-1:0]  acc_w_reg, acc_r_reg;
    logic                         sat_seen_reg;
    logic                         out_valid_reg;
    logic signed [63:0]           out_s_reg, out_mu_reg;
    logic                         out_sat_reg;

    logic [W_WIDTH-1:0]   mag;
    logic [S2_WIDTH:0]    rem_shift;
    logic                 rem_ge;
    logic [32:0]          lim;
    logic                 q_over;
    logic signed [ACC_WIDTH:0] sum_w, sum_r;
    logic signed [ACC_WIDTH-1:0] new_w, new_r;
    logic                 sat_w, sat_r, item_sat;
    logic                 out_free;

    // magnitude of the incoming weight
    assign mag = q_data.w[W_WIDTH-1] ? W_WIDTH'(-q_data.w) : W_WIDTH'(q_data.w);

    // one restoring step
    assign rem_shift = {rem_reg, num_reg[NW-1]};
    assign rem_ge    = rem_shift >= {1'b0, ent_reg.s2};

    // quotient limit by sign
    assign lim    = neg_reg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    assign q_over = ovf_reg || (quo_reg > lim);

    // saturating adds
    assign sum_w = 65'(acc_w_reg) + 65'(pw_reg);
    assign sum_r = 65'(acc_r_reg) + 65'(pr_reg);
    assign sat_w = sum_w[ACC_WIDTH] != sum_w[ACC_WIDTH-1];
    assign sat_r = sum_r[ACC_WIDTH] != sum_r[ACC_WIDTH-1];
    assign new_w = sat_w ? (sum_w[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                             : {1'b0, {(ACC_WIDTH-1){1'b1}}})
                         : sum_w[ACC_WIDTH-1:0];
    assign new_r = sat_r ? (sum_r[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                             : {1'b0, {(ACC_WIDTH-1){1'b1}}})
                         : sum_r[ACC_WIDTH-1:0];
    assign item_sat = sat_w || sat_r || ent_reg.res_sat || div_sat_reg;

    assign out_free = !out_valid_reg || pop;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign empty    = !out_valid_reg;
    assign sum_s    = out_s_reg;
    assign sum_s_mu = out_mu_reg;
    assign saturated = out_sat_reg;

    // sequencer, accumulators and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            acc_w_reg     <= '0;
            acc_r_reg     <= '0;
            sat_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && pop && !(state_reg == ST_ACC && ent_reg.last))
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        ent_reg   <= q_data;
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                        neg_reg   <= q_data.w[W_WIDTH-1];
                        zero_reg  <= (q_data.w == '0);
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        num_reg   <= {mag, {(2*FRAC_BITS){1'b0}}};
                    end
                end
                ST_DIV:
                begin
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                    rem_reg <= rem_ge ? S2_WIDTH'(rem_shift - {1'b0, ent_reg.s2})
                                      : rem_shift[S2_WIDTH-1:0];
                    quo_reg <= {quo_reg[31:0], rem_ge};
                    ovf_reg <= ovf_reg || quo_reg[32];
                    if (cnt_reg == CW'(NW - 1))
                        state_reg <= ST_FIN;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_FIN:
                begin
                    if (zero_reg)
                    begin
                        ratio_reg   <= '0;
                        div_sat_reg <= 1'b0;
                    end
                    else
                    begin
                        div_sat_reg <= q_over;
                        ratio_reg   <= neg_reg ? -(q_over ? lim[31:0] : quo_reg[31:0])
                                               : (q_over ? lim[31:0] : quo_reg[31:0]);
                    end
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    pw_reg    <= 64'(ent_reg.w) * 64'(ratio_reg);
                    pr_reg    <= 64'(ent_reg.res) * 64'(ratio_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (!ent_reg.last)
                    begin
                        acc_w_reg    <= new_w;
                        acc_r_reg    <= new_r;
                        sat_seen_reg <= sat_seen_reg || item_sat;
                        state_reg    <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_s_reg     <= new_w;
                        out_mu_reg    <= new_r;
                        out_sat_reg   <= sat_seen_reg || item_sat;
                        out_valid_reg <= 1'b1;
                        acc_w_reg     <= '0;
                        acc_r_reg     <= '0;
                        sat_seen_reg  <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_s_reg))
        else $error("result overwritten");

    // divider count stays within the dividend width
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(NW))
        else $error("divider count out of range");

    // queue is only read from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == ST_DIV)
        else $error("queue read outside idle");

endmodule
`default_nettype wire

// ----- rtl/weighted_residual_sums_top.sv -----
// top level of the weighted residual sums block
`default_nettype none
// Streams one matrix element per request and keeps two saturating Q.2F sums,
// weight times ratio and ratio times residual, given out and cleared on the
// request marked last. Each request passes through the back end's bit-serial
// restoring divider, which forms ratio = w / std_dev^2, one quotient bit per
// cycle; the back end takes a new request only after finishing the last. The
// front end takes requests into a two-stage pipeline and a two-entry queue,
// so a few requests can be accepted ahead of the divider.
module weighted_residual_sums_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          op,
    input  wire logic signed [31:0]  coef_a,
    input  wire logic signed [31:0]  coef_b,
    input  wire logic signed [31:0]  data_value,
    input  wire logic signed [31:0]  approx_value,
    input  wire logic [30:0]         std_dev,
    input  wire logic signed [31:0]  change,
    input  wire logic                last,
    output logic                     empty,
    input  wire logic                pop,
    output logic signed [63:0]       sum_s,
    output logic signed [63:0]       sum_s_mu,
    output logic                     saturated
);
    import wrs_pkg::*;

    wrs_entry_t f_data, b_data;
    logic       f_push, f_full, b_pop, b_empty;

    // classification front end
    wrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .coef_a(coef_a), .coef_b(coef_b), .data_value(data_value),
        .approx_value(approx_value), .std_dev(std_dev), .change(change),
        .last(last), .q_push(f_push), .q_data(f_data), .q_full(f_full)
    );

    // decoupling queue
    wrs_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_en(f_push), .wr_data(f_data),
        .q_full(f_full), .rd_en(b_pop), .rd_data(b_data), .q_empty(b_empty)
    );

    // divide and accumulate back end
    wrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_data(b_data), .q_empty(b_empty),
        .q_pop(b_pop), .empty(empty), .pop(pop), .sum_s(sum_s),
        .sum_s_mu(sum_s_mu), .saturated(saturated)
    );

endmodule
`default_nettype wire
